// File: rtl/dss_pkg.sv
`default_nettype none

package dss_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ACTION_W      = 3;
  localparam int DATA_W        = 32;
  localparam int STATUS_W      = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_LO = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_HI = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_LO  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_HI  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LIST_LO = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_LIST_HI = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // one result on its way from the sequencer to the output queue
  typedef struct packed {
    logic                vld;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic                use_mem;
  } dss_res_t;

endpackage

`default_nettype wire

// File: rtl/dss_mem.sv
`default_nettype none

module dss_mem
  import dss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/dss_ctrl.sv
`default_nettype none

module dss_ctrl
  import dss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [DATA_W-1:0]   in_value,
  input  wire logic                issue_ok,
  output logic                     mem_we,
  output logic      [AW-1:0]       mem_waddr,
  output logic      [DATA_W-1:0]   mem_wdata,
  output logic                     mem_re,
  output logic      [AW-1:0]       mem_raddr,
  output dss_res_t                 res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_IDX   = AW'(DEPTH - 1);

  logic          state_r, state_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          dir_r, dir_nxt;   // 1: walking the high stack upward
  dss_res_t      res_r, res_nxt;

  logic          accept;
  logic          full;
  logic          lst;
  logic [AW-1:0] lo_top;
  logic [AW-1:0] hi_top;
  logic [AW-1:0] hi_push;

  assign in_ready  = (state_r == S_IDLE) && issue_ok;
  assign accept    = in_valid && in_ready;
  assign full      = ({1'b0, lo_r} + {1'b0, hi_r}) >= DEPTH_SUM;
  assign lo_top    = AW'(lo_r - CW'(1));
  assign hi_top    = AW'(DEPTH_CNT - hi_r);
  assign hi_push   = AW'(DEPTH_CNT - hi_r - CW'(1));
  assign lst       = dir_r ? (ptr_r == TOP_IDX) : (ptr_r == '0);
  assign mem_wdata = in_value;

  // a write and a later read of the same entry never share a cycle, so the
  // array needs no bypass
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ptr_nxt   = ptr_r;
    dir_nxt   = dir_r;
    res_nxt   = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state_r == S_LIST) begin
      if (issue_ok) begin
        mem_re          = 1'b1;
        mem_raddr       = ptr_r;
        res_nxt.vld     = 1'b1;
        res_nxt.status  = ST_OK;
        res_nxt.use_mem = 1'b1;
        res_nxt.last    = lst;
        ptr_nxt         = dir_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
        if (lst) begin
          state_nxt = S_IDLE;
        end
      end
    end else if (accept) begin
      unique case (in_action)
        ACT_PUSH_LO, ACT_PUSH_HI: begin
          res_nxt.vld  = 1'b1;
          res_nxt.last = 1'b1;
          if (full) begin
            res_nxt.status = ST_OVERFLOW;
          end else begin
            res_nxt.status = ST_OK;
            mem_we         = 1'b1;
            if (in_action == ACT_PUSH_LO) begin
              mem_waddr = AW'(lo_r);
              lo_nxt    = lo_r + CW'(1);
            end else begin
              mem_waddr = hi_push;
              hi_nxt    = hi_r + CW'(1);
            end
          end
        end
        ACT_POP_LO: begin
          res_nxt.vld  = 1'b1;
          res_nxt.last = 1'b1;
          if (lo_r == '0) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_nxt.status  = ST_OK;
            res_nxt.use_mem = 1'b1;
            mem_re          = 1'b1;
            mem_raddr       = lo_top;
            lo_nxt          = lo_r - CW'(1);
          end
        end
        ACT_POP_HI: begin
          res_nxt.vld  = 1'b1;
          res_nxt.last = 1'b1;
          if (hi_r == '0) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_nxt.status  = ST_OK;
            res_nxt.use_mem = 1'b1;
            mem_re          = 1'b1;
            mem_raddr       = hi_top;
            hi_nxt          = hi_r - CW'(1);
          end
        end
        ACT_LIST_LO: begin
          res_nxt.vld = 1'b1;
          if (lo_r == '0) begin
            res_nxt.status = ST_EMPTY;
            res_nxt.last   = 1'b1;
          end else begin
            res_nxt.status  = ST_OK;
            res_nxt.use_mem = 1'b1;
            mem_re          = 1'b1;
            mem_raddr       = lo_top;
            res_nxt.last    = (lo_r == CW'(1));
            if (lo_r != CW'(1)) begin
              state_nxt = S_LIST;
              dir_nxt   = 1'b0;
              ptr_nxt   = lo_top - AW'(1);
            end
          end
        end
        ACT_LIST_HI: begin
          res_nxt.vld = 1'b1;
          if (hi_r == '0) begin
            res_nxt.status = ST_EMPTY;
            res_nxt.last   = 1'b1;
          end else begin
            res_nxt.status  = ST_OK;
            res_nxt.use_mem = 1'b1;
            mem_re          = 1'b1;
            mem_raddr       = hi_top;
            res_nxt.last    = (hi_r == CW'(1));
            if (hi_r != CW'(1)) begin
              state_nxt = S_LIST;
              dir_nxt   = 1'b1;
              ptr_nxt   = hi_top + AW'(1);
            end
          end
        end
        default: begin
          // unused codes: no result, no change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lo_r    <= '0;
      hi_r    <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    dir_r <= dir_nxt;
  end

  assign res = res_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, lo_r} + {1'b0, hi_r}) <= DEPTH_SUM)
    else $error("stack counts exceed store depth");

  a_list_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> !in_ready)
    else $error("input taken during list walk");

  a_mem_result_read: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.vld && res_r.use_mem) |-> $past(mem_re))
    else $error("memory result without a read");
`endif

endmodule

`default_nettype wire

// File: rtl/dual_stack_shared_store_unit.sv
// Two stacks sharing one store of STORE_DEPTH 32-bit words: stack one grows
// up from entry 0, stack two grows down from the last entry.
// Input channel: in_tuser carries the action (push, pop or list of either
// stack), in_tdata the signed word to push. Codes 6 and 7 are dropped.
// Result channel: out_tdata carries the popped or listed word (zero unless
// status is ok), out_tuser the status (ok, overflow, empty) and out_tlast
// marks the final word caused by an input word.
// A result passes through the result register, beside the registered store
// read, and then the output queue before it shows on out_tvalid.
// Push and pop make one store access per word, and a new one can be taken
// before the last result is out while the output queue has room; a list
// makes one store read per element, and in_tready stays low during the walk.
// Reset clears both stack counts; store contents are not cleared and need
// no clearing pass, since only written entries are ever read.
// A two-word output queue decouples the receiver: while out_tready is low
// the queue fills, then in_tready drops and list walks pause with no word
// lost or repeated.
`default_nettype none

module dual_stack_shared_store_unit
  import dss_pkg::*;
#(
  parameter int STORE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [DATA_W-1:0]   in_tdata,   // [31:0] value
  input  wire logic [ACTION_W-1:0] in_tuser,   // [2:0] action
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [DATA_W-1:0]   out_tdata,  // [31:0] data
  output logic      [STATUS_W-1:0] out_tuser,  // [1:0] status
  output logic                     out_tlast
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  dss_res_t          res;
  logic              issue_ok;

  dss_ctrl #(.DEPTH(STORE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata),
    .issue_ok  (issue_ok),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  dss_mem #(.DEPTH(STORE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // two-word output queue
  logic [DATA_W-1:0]   q_data   [2];
  logic [STATUS_W-1:0] q_status [2];
  logic                q_last   [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic                enq;
  logic                deq;

  assign enq        = res.vld;
  assign out_tvalid = (cnt_r != 2'd0);
  assign deq        = out_tvalid && out_tready;
  assign out_tdata  = q_data[rd_ptr_r];
  assign out_tuser  = q_status[rd_ptr_r];
  assign out_tlast  = q_last[rd_ptr_r];

  // a new result may start only if the queue still has room when it lands
  assign issue_ok = ({1'b0, cnt_r} + {2'b00, res.vld} - {2'b00, deq}) <= 3'd1;

  always_ff @(posedge clk) begin
    if (enq) begin
      q_data[wr_ptr_r]   <= res.use_mem ? mem_rdata : '0;
      q_status[wr_ptr_r] <= res.status;
      q_last[wr_ptr_r]   <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, deq};
    end
  end

`ifndef ASSERT_OFF
  a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(enq && !deq && (cnt_r == 2'd2)))
    else $error("result written into a full output queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output queue count out of range");
`endif

endmodule

`default_nettype wire
